@@ rtl/abkf_pkg.sv @@
package abkf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW = 32;
  // wide enough for num << FRAC_BITS with sign
  localparam int NW = DW + FRAC_BITS + 1;
  localparam int DIV_CNT_W = $clog2(NW + 1);

  localparam logic signed [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] ONE = DW'(64'sd1 <<< FRAC_BITS);

  localparam int PADDR_W = 4;
  localparam logic [PADDR_W-1:0] ADDR_DT = 4'h0;
  localparam logic [PADDR_W-1:0] ADDR_QA = 4'h4;
  localparam logic [PADDR_W-1:0] ADDR_QG = 4'h8;
  localparam logic [PADDR_W-1:0] ADDR_R = 4'hc;

  // datapath operations, one per controller step
  typedef enum logic [4:0] {
    OP_NONE     = 5'd0,
    OP_LOAD     = 5'd1,  // latch input, rate = sat(gyro - bias)
    OP_MUL_ANG  = 5'd2,  // angle += mul(rate, dt)
    OP_PD0A     = 5'd3,  // tmp = sat(qa - p01)
    OP_PD0B     = 5'd4,  // tmp = sat(tmp - p10)
    OP_MUL_P00  = 5'd5,  // p00 += mul(tmp, dt)
    OP_NEGP11   = 5'd6,  // tmp = sat(-p11)
    OP_MUL_P01  = 5'd7,  // p01 += mul(tmp, dt); keep product in prod
    OP_ADD_P10  = 5'd8,  // p10 += prod
    OP_MUL_P11  = 5'd9,  // p11 += mul(qg, dt)
    OP_E        = 5'd10, // e = sat(r + p00), err = sat(accel - angle)
    OP_DIV0     = 5'd11, // start k0 = div(p00, e)
    OP_DIV1     = 5'd12, // start k1 = div(p10, e)
    OP_MUL_ANG2 = 5'd13, // angle += mul(k0, err)
    OP_MUL_BIAS = 5'd14, // bias += mul(k1, err)
    OP_RATE     = 5'd15, // rate = sat(gyro - bias), latch t0 t1
    OP_C00      = 5'd16, // p00 -= mul(k0, t0)
    OP_C01      = 5'd17, // p01 -= mul(k0, t1)
    OP_C10      = 5'd18, // p10 -= mul(k1, t0)
    OP_C11      = 5'd19  // p11 -= mul(k1, t1)
  } op_t;

  typedef struct packed {
    op_t  op;
    logic mul_go;  // product register loads this cycle
    logic acc_go;  // destination updates from product register
    logic div_go;  // start the divider
    logic k_sel;   // divider result goes to k1
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } stat_t;

  function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b,
                                                   input logic sub);
    logic signed [DW:0] s;
    s = sub ? ({a[DW-1], a} - {b[DW-1], b}) : ({a[DW-1], a} + {b[DW-1], b});
    if (s[DW] != s[DW-1]) return s[DW] ? S_MIN : S_MAX;
    return s[DW-1:0];
  endfunction

endpackage

@@ rtl/abkf_div.sv @@
// restoring divider on magnitudes, one quotient bit per cycle
module abkf_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [abkf_pkg::DW-1:0] num,
  input  logic signed [abkf_pkg::DW-1:0] den,
  output logic                          busy,
  output logic signed [abkf_pkg::DW-1:0] quo
);
  import abkf_pkg::*;

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0] rem_r, rem_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic neg_r, neg_nxt, zero_r, zero_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [DW:0] trial;
  logic [DW-1:0] num_mag, den_mag;
  logic [NW-1:0] mag;

  assign num_mag = num[DW-1] ? DW'(-num) : num;
  assign den_mag = den[DW-1] ? DW'(-den) : den;
  assign trial = {rem_r[DW-1:0], q_r[NW-1]} - {1'b0, d_r};

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    d_nxt = d_r;
    neg_nxt = neg_r;
    zero_nxt = zero_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt = {1'b0, num_mag, {FRAC_BITS{1'b0}}};
      rem_nxt = '0;
      d_nxt = den_mag;
      neg_nxt = num[DW-1] ^ den[DW-1];
      zero_nxt = (den == '0);
      cnt_nxt = DIV_CNT_W'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DW]) begin
        rem_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DW-1:0], q_r[NW-1]};
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    d_r <= d_nxt;
    neg_r <= neg_nxt;
    zero_r <= zero_nxt;
  end

  always_comb begin
    mag = q_r;
    if (zero_r) quo = '0;
    else if (!neg_r) quo = (mag > NW'(S_MAX)) ? S_MAX : mag[DW-1:0];
    else quo = (mag >= NW'({1'b1, {(DW-1){1'b0}}})) ? S_MIN : DW'(-mag[DW-1:0]);
  end

  assign busy = busy_r;
endmodule

@@ rtl/abkf_datapath.sv @@
module abkf_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  abkf_pkg::cmd_t                 cmd,
  output abkf_pkg::stat_t                stat,
  input  logic signed [abkf_pkg::DW-1:0] accel,
  input  logic signed [abkf_pkg::DW-1:0] gyro,
  input  logic [16:0]                    dt,
  input  logic [16:0]                    qa,
  input  logic [16:0]                    qg,
  input  logic [24:0]                    rn,
  output logic signed [abkf_pkg::DW-1:0] angle_out,
  output logic signed [abkf_pkg::DW-1:0] rate_out
);
  import abkf_pkg::*;

  logic signed [DW-1:0] ang_r, bias_r, p00_r, p01_r, p10_r, p11_r;
  logic signed [DW-1:0] accel_r, gyro_r, tmp_r, rate_r, e_r, err_r;
  logic signed [DW-1:0] k0_r, k1_r, t0_r, t1_r, prod_r;
  logic signed [DW-1:0] ma, mb, prod_nxt, quo;
  logic signed [2*DW-1:0] p;
  logic signed [2*DW-FRAC_BITS-1:0] sh;
  logic div_busy, div_busy_d;
  logic signed [DW-1:0] div_num;

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_MUL_ANG:  begin ma = rate_r; mb = DW'(dt); end
      OP_MUL_P00:  begin ma = tmp_r; mb = DW'(dt); end
      OP_MUL_P01:  begin ma = tmp_r; mb = DW'(dt); end
      OP_MUL_P11:  begin ma = DW'(qg); mb = DW'(dt); end
      OP_MUL_ANG2: begin ma = k0_r; mb = err_r; end
      OP_MUL_BIAS: begin ma = k1_r; mb = err_r; end
      OP_C00:      begin ma = k0_r; mb = t0_r; end
      OP_C01:      begin ma = k0_r; mb = t1_r; end
      OP_C10:      begin ma = k1_r; mb = t0_r; end
      OP_C11:      begin ma = k1_r; mb = t1_r; end
      default:     begin ma = '0; mb = '0; end
    endcase
  end

  // round half up then arithmetic shift, saturate
  always_comb begin
    p = ma * mb + (2*DW)'(64'sd1 <<< (FRAC_BITS - 1));
    sh = p[2*DW-1:FRAC_BITS];
    if (sh > (2*DW-FRAC_BITS)'(S_MAX)) prod_nxt = S_MAX;
    else if (sh < (2*DW-FRAC_BITS)'(S_MIN)) prod_nxt = S_MIN;
    else prod_nxt = sh[DW-1:0];
  end

  assign div_num = cmd.k_sel ? p10_r : p00_r;

  abkf_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_go),
    .num  (div_num),
    .den  (e_r),
    .busy (div_busy),
    .quo  (quo)
  );

  logic k_dst_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r <= '0;
      bias_r <= '0;
      p00_r <= ONE;
      p01_r <= '0;
      p10_r <= '0;
      p11_r <= ONE;
      div_busy_d <= 1'b0;
      k_dst_r <= 1'b0;
    end else begin
      div_busy_d <= div_busy;
      if (cmd.div_go) k_dst_r <= cmd.k_sel;
      if (div_busy_d && !div_busy) begin
        if (k_dst_r) k1_r <= quo;
        else k0_r <= quo;
      end
      if (cmd.mul_go) prod_r <= prod_nxt;
      case (cmd.op)
        OP_LOAD: begin
          accel_r <= accel;
          gyro_r <= gyro;
          rate_r <= sat_add(gyro, bias_r, 1'b1);
        end
        OP_PD0A:  tmp_r <= sat_add(DW'(qa), p01_r, 1'b1);
        OP_PD0B:  tmp_r <= sat_add(tmp_r, p10_r, 1'b1);
        OP_NEGP11: tmp_r <= sat_add('0, p11_r, 1'b1);
        OP_E: begin
          e_r <= sat_add(DW'(rn), p00_r, 1'b0);
          err_r <= sat_add(accel_r, ang_r, 1'b1);
        end
        OP_RATE: begin
          rate_r <= sat_add(gyro_r, bias_r, 1'b1);
          t0_r <= p00_r;
          t1_r <= p01_r;
        end
        default: ;
      endcase
      // accumulate previous step's product
      if (cmd.acc_go) begin
        case (cmd.op)
          OP_PD0A:     ang_r <= sat_add(ang_r, prod_r, 1'b0);
          OP_NEGP11:   p00_r <= sat_add(p00_r, prod_r, 1'b0);
          OP_ADD_P10: begin
            p01_r <= sat_add(p01_r, prod_r, 1'b0);
            p10_r <= sat_add(p10_r, prod_r, 1'b0);
          end
          OP_E:        p11_r <= sat_add(p11_r, prod_r, 1'b0);
          OP_MUL_BIAS: ang_r <= sat_add(ang_r, prod_r, 1'b0);
          OP_NONE:     bias_r <= sat_add(bias_r, prod_r, 1'b0);
          OP_C01:      p00_r <= sat_add(p00_r, prod_r, 1'b1);
          OP_C10:      p01_r <= sat_add(p01_r, prod_r, 1'b1);
          OP_C11:      p10_r <= sat_add(p10_r, prod_r, 1'b1);
          OP_MUL_ANG:  p11_r <= sat_add(p11_r, prod_r, 1'b1);
          default: ;
        endcase
      end
    end
  end

  assign stat.div_busy = div_busy | div_busy_d;
  assign angle_out = ang_r;
  assign rate_out = rate_r;
endmodule

@@ rtl/abkf_ctrl.sv @@
module abkf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  abkf_pkg::stat_t stat,
  input  logic            out_free,
  output abkf_pkg::cmd_t  cmd,
  output logic            idle
);
  import abkf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RUN  = 6'b000010,
    S_DIV  = 6'b000100,
    S_RUN2 = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [4:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    cmd = '0;
    cmd.op = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          state_nxt = S_RUN;
          step_nxt = '0;
        end
      end
      S_RUN: begin
        step_nxt = step_r + 1'b1;
        case (step_r)
          5'd0: begin cmd.op = OP_MUL_ANG; cmd.mul_go = 1'b1; end
          5'd1: begin cmd.op = OP_PD0A; cmd.acc_go = 1'b1; end
          5'd2: cmd.op = OP_PD0B;
          5'd3: begin cmd.op = OP_MUL_P00; cmd.mul_go = 1'b1; end
          5'd4: begin cmd.op = OP_NEGP11; cmd.acc_go = 1'b1; end
          5'd5: begin cmd.op = OP_MUL_P01; cmd.mul_go = 1'b1; end
          5'd6: begin cmd.op = OP_ADD_P10; cmd.acc_go = 1'b1; end
          5'd7: begin cmd.op = OP_MUL_P11; cmd.mul_go = 1'b1; end
          5'd8: begin cmd.op = OP_E; cmd.acc_go = 1'b1; end
          5'd9: begin
            cmd.op = OP_DIV0;
            cmd.div_go = 1'b1;
            state_nxt = S_DIV;
          end
          default: begin
            cmd.op = OP_DIV1;
            cmd.div_go = 1'b1;
            cmd.k_sel = 1'b1;
            state_nxt = S_DIV;
          end
        endcase
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          state_nxt = (step_r == 5'd10) ? S_RUN : S_RUN2;
          if (step_r == 5'd10) step_nxt = 5'd10;
          else step_nxt = '0;
        end
      end
      S_RUN2: begin
        step_nxt = step_r + 1'b1;
        case (step_r)
          5'd0: begin cmd.op = OP_MUL_ANG2; cmd.mul_go = 1'b1; end
          5'd1: begin
            cmd.op = OP_MUL_BIAS;
            cmd.mul_go = 1'b1;
            cmd.acc_go = 1'b1;
          end
          5'd2: begin cmd.op = OP_NONE; cmd.acc_go = 1'b1; end
          5'd3: cmd.op = OP_RATE;
          5'd4: begin cmd.op = OP_C00; cmd.mul_go = 1'b1; end
          5'd5: begin cmd.op = OP_C01; cmd.mul_go = 1'b1; cmd.acc_go = 1'b1; end
          5'd6: begin cmd.op = OP_C10; cmd.mul_go = 1'b1; cmd.acc_go = 1'b1; end
          5'd7: begin cmd.op = OP_C11; cmd.mul_go = 1'b1; cmd.acc_go = 1'b1; end
          default: begin
            // last product subtracts from p11
            cmd.op = OP_MUL_ANG;
            cmd.acc_go = 1'b1;
            state_nxt = S_FIN;
          end
        endcase
      end
      S_FIN: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // div1 comes from S_RUN step 10; step 9 enters DIV with step 10
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
    end
  end

  assign idle = (state_r == S_IDLE);
endmodule

@@ rtl/angle_bias_kalman_filter_unit.sv @@
// two-state kalman filter over tilt angle and gyro bias, signed q16.16
//
// in channel: one request carries accel_angle and gyro_rate; out channel
// returns filtered_angle and the bias-corrected filtered_rate, one result
// per request, in order.
// the controller walks a fixed schedule over one shared 32x32 multiplier
// and a restoring divider that produces one quotient bit per cycle; each
// gain division holds the schedule until the divider is done and the
// quotient is handed over. one request is worked on at a time; in_tready
// is high while the unit idles.
// the result sits in an output register; while out_tready is low it holds,
// and the next request may be accepted and computed meanwhile, waiting
// only for the output register to free up before it is written.
// reset (synchronous, active low) restores the registers to their reset
// values, angle and bias to zero and the covariance to identity.
// configuration is to be written over the apb port only while the unit is
// idle; the user is bound to this, the unit itself does not enforce it.
module angle_bias_kalman_filter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // accel_angle[31:0], gyro_rate[63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // filtered_angle[31:0], filtered_rate[63:32]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [abkf_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import abkf_pkg::*;

  logic [16:0] dt_r, qa_r, qg_r;
  logic [24:0] rn_r;
  cmd_t cmd;
  stat_t stat;
  logic idle, start, out_free;
  logic signed [DW-1:0] angle_w, rate_w;
  logic out_valid_r;
  logic [63:0] out_data_r;

  assign cfg_pready = 1'b1;

  // register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= 17'd328;
      qa_r <= 17'd66;
      qg_r <= 17'd328;
      rn_r <= 25'd32768;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr)
        ADDR_DT: dt_r <= cfg_pwdata[16:0];
        ADDR_QA: qa_r <= cfg_pwdata[16:0];
        ADDR_QG: qg_r <= cfg_pwdata[16:0];
        ADDR_R:  rn_r <= cfg_pwdata[24:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      ADDR_DT: cfg_prdata = {15'd0, dt_r};
      ADDR_QA: cfg_prdata = {15'd0, qa_r};
      ADDR_QG: cfg_prdata = {15'd0, qg_r};
      ADDR_R:  cfg_prdata = {7'd0, rn_r};
      default: cfg_prdata = '0;
    endcase
  end

  assign in_tready = idle;
  assign start = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  abkf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .stat    (stat),
    .out_free(out_free),
    .cmd     (cmd),
    .idle    (idle)
  );

  abkf_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .accel    (in_tdata[31:0]),
    .gyro     (in_tdata[63:32]),
    .dt       (dt_r),
    .qa       (qa_r),
    .qg       (qg_r),
    .rn       (rn_r),
    .angle_out(angle_w),
    .rate_out (rate_w)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) out_data_r <= {rate_w, angle_w};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  // a result is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

  // no new request while the filter works
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_tready)
    else $error("request accepted while busy");

  // divider only starts when idle
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_go |-> !stat.div_busy)
    else $error("divider restarted while busy");
endmodule

@@ bench/abkf_checker.sv @@
module abkf_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [abkf_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);
  import abkf_pkg::*;

  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;

  logic [16:0] dt_reg, qa_reg, qg_reg;
  logic [24:0] r_reg;
  longint ang, bias, p00, p01, p10, p11;
  logic [63:0] expected_q[$];

  function automatic longint clamp(input longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    longint p;
    p = a * b + (64'sd1 <<< (FRAC_BITS - 1));
    return clamp(p >>> FRAC_BITS);
  endfunction

  function automatic longint qdiv(input longint n, input longint d);
    if (d == 0) return 0;
    return clamp((n * (64'sd1 <<< FRAC_BITS)) / d);
  endfunction

  // one filter step, returns {rate, angle}
  function automatic logic [63:0] kalman_step(input logic [63:0] req);
    longint accel, gyro, dt, rate, pd0, np11, e, k0, k1, err, t0, t1;
    accel = longint'(signed'(req[31:0]));
    gyro = longint'(signed'(req[63:32]));
    dt = longint'(dt_reg);
    rate = clamp(gyro - bias);
    ang = clamp(ang + qmul(rate, dt));
    pd0 = clamp(clamp(longint'(qa_reg) - p01) - p10);
    np11 = clamp(-p11);
    p00 = clamp(p00 + qmul(pd0, dt));
    p01 = clamp(p01 + qmul(np11, dt));
    p10 = clamp(p10 + qmul(np11, dt));
    p11 = clamp(p11 + qmul(longint'(qg_reg), dt));
    e = clamp(longint'(r_reg) + p00);
    k0 = qdiv(p00, e);
    k1 = qdiv(p10, e);
    err = clamp(accel - ang);
    ang = clamp(ang + qmul(k0, err));
    bias = clamp(bias + qmul(k1, err));
    rate = clamp(gyro - bias);
    t0 = p00;
    t1 = p01;
    p00 = clamp(p00 - qmul(k0, t0));
    p01 = clamp(p01 - qmul(k0, t1));
    p10 = clamp(p10 - qmul(k1, t0));
    p11 = clamp(p11 - qmul(k1, t1));
    return {rate[31:0], ang[31:0]};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d", what, signed'(got), signed'(want));
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst_n) begin
      dt_reg <= 17'd328;
      qa_reg <= 17'd66;
      qg_reg <= 17'd328;
      r_reg <= 25'd32768;
      ang = 0;
      bias = 0;
      p00 = 64'sd1 <<< FRAC_BITS;
      p01 = 0;
      p10 = 0;
      p11 = 64'sd1 <<< FRAC_BITS;
      expected_q.delete();
      fail_count = 0;
      result_count = 0;
      pending_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        case (cfg_paddr)
          ADDR_DT: dt_reg <= cfg_pwdata[16:0];
          ADDR_QA: qa_reg <= cfg_pwdata[16:0];
          ADDR_QG: qg_reg <= cfg_pwdata[16:0];
          ADDR_R:  r_reg <= cfg_pwdata[24:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) expected_q.push_back(kalman_step(in_tdata));
      if (out_tvalid && out_tready) begin
        result_count++;
        if (expected_q.size() == 0) begin
          $display("unexpected result %h", out_tdata);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_tdata[31:0] !== want[31:0])
            report_mismatch("filtered_angle", out_tdata[31:0], want[31:0]);
          if (out_tdata[63:32] !== want[63:32])
            report_mismatch("filtered_rate", out_tdata[63:32], want[63:32]);
        end
      end
      pending_count <= expected_q.size();
    end
  end
endmodule

@@ bench/angle_bias_kalman_filter_unit_tb.sv @@
module angle_bias_kalman_filter_unit_tb;
  import abkf_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count, pending_count, result_count;
  int idle_cycles = 0;
  int sent_count = 0;
  int out_gap = 0;
  int gap_draw;
  bit no_stall = 1'b0;

  // 12 unit period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  angle_bias_kalman_filter_unit DUT (.*);

  abkf_checker checker_i (.*);

  // watchdog: cycles with no request or result moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d quiet cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side holds ready low for a gap drawn with $urandom_range after each result, none in quiet stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap <= 0;
    end else if (out_tvalid && out_tready) begin
      gap_draw = no_stall ? 0 : $urandom_range(0, 10);
      out_tready <= (gap_draw == 0);
      out_gap <= gap_draw;
    end else if (!out_tready) begin
      if (out_gap <= 1) out_tready <= 1'b1;
      if (out_gap > 0) out_gap <= out_gap - 1;
    end
  end

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
    // setup then access phase
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [31:0] accel, input logic [31:0] gyro);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 10);
    repeat (gap) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {gyro, accel};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    in_tvalid <= 1'b0;
    sent_count++;
    @(posedge clk);
  endtask

  // let every outstanding result drain, then the schedule tail
  task automatic drain;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_filter(input logic [31:0] dt, input logic [31:0] qa,
                            input logic [31:0] qg, input logic [31:0] r);
    drain();
    write_reg(ADDR_DT, dt);
    write_reg(ADDR_QA, qa);
    write_reg(ADDR_QG, qg);
    write_reg(ADDR_R, r);
  endtask

  // mostly plausible tilt data, sometimes full-range noise
  function automatic logic [31:0] pick_value(input int spread);
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  task automatic random_phase(input int count, input int spread);
    repeat (count) send_sample(pick_value(spread), pick_value(spread));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: defaults, field extremes, saturation
    send_sample(32'h0000_0000, 32'h0000_0000);
    send_sample(32'h7fff_ffff, 32'h7fff_ffff);
    send_sample(32'h8000_0000, 32'h8000_0000);
    send_sample(32'h7fff_ffff, 32'h8000_0000);
    send_sample(32'h8000_0000, 32'h7fff_ffff);
    send_sample(32'hffff_ffff, 32'h0000_0001);
    send_sample(32'h0001_0000, 32'hfffe_0000);
    send_sample(32'h5555_5555, 32'haaaa_aaaa);
    send_sample(32'haaaa_aaaa, 32'h5555_5555);
    // dt and process noise at 1.0, r at 256.0
    set_filter(32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h100_0000);
    send_sample(32'h7fff_ffff, 32'h8000_0000);
    send_sample(32'h8000_0000, 32'h7fff_ffff);
    send_sample(32'h0123_4567, 32'hfedc_ba98);
    // dt and r at their low ends, zero process noise; all-ones register bits
    set_filter(32'h1, 32'h0, 32'h0, 32'h1);
    send_sample(32'h7fff_ffff, 32'h7fff_ffff);
    send_sample(32'h8000_0000, 32'h0000_0000);
    set_filter(32'h1_ffff, 32'h1_ffff, 32'h1_ffff, 32'h1ff_ffff);
    send_sample(32'h0000_ffff, 32'hffff_0000);
    send_sample(32'h8000_0000, 32'h8000_0000);
    // zero dt and zero r, out of range: innovation variance may cross zero
    set_filter(32'h0, 32'h0, 32'h0, 32'h0);
    send_sample(32'h0000_0000, 32'h0000_0000);
    send_sample(32'h7fff_ffff, 32'h7fff_ffff);
    send_sample(32'h8000_0000, 32'h8000_0000);

    // random phases through several settings
    set_filter(328, 66, 328, 32768);
    random_phase(200, 32'h5a_0000);
    set_filter($urandom_range(1, 65536), $urandom_range(0, 65536),
               $urandom_range(0, 65536), $urandom_range(1, 16777216));
    random_phase(150, 32'h7fff_0000);
    no_stall = 1'b1;
    set_filter(6554, 655, 3277, 655);
    random_phase(100, 32'h20_0000);
    no_stall = 1'b0;
    set_filter($urandom, $urandom, $urandom, $urandom);
    random_phase(150, 32'h7fff_0000);
    set_filter(1, 65536, 0, 1);
    random_phase(100, 32'h5a_0000);
    set_filter(65536, 0, 65536, 16777216);
    random_phase(100, 32'h5a_0000);

    drain();
    $display("sent %0d samples, checked %0d results", sent_count, result_count);
    $display("config phases covered default, extreme and random register values");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
